@@ src/ipc_frame_deframer_top_assert.svh @@
// Assertion macros shared by the checker of the IPC frame deframer.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef IPC_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define IPC_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define IPCFD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define IPCFD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/ipcfd_pkg.sv @@
// Package of the IPC frame deframer: payload types, status and kind codes,
// header byte counts and register indexes. Depends on nothing.
package ipcfd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    StNeed     = 3'd0,
    StLogByte  = 3'd1,
    StLogEnd   = 3'd2,
    StShutdown = 3'd3,
    StReady    = 3'd4,
    StActivate = 3'd5,
    StInvalid  = 3'd6,
    StDead     = 3'd7
  } status_e;

  // Frame kinds, in tag match priority order
  typedef enum logic [1:0] {
    KindLog      = 2'd0,
    KindShutdown = 2'd1,
    KindReady    = 2'd2,
    KindActivate = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegTagLogLine    = 3'd0,
    RegTagShutdown   = 3'd1,
    RegTagReadyQuery = 3'd2,
    RegTagActivate   = 3'd3,
    RegMaxLogLength  = 3'd4
  } reg_e;

  // Header byte counts: tag, tag plus length, tag plus nonce
  localparam logic [3:0] TagBytes      = 4'd4;
  localparam logic [3:0] LogHdrBytes   = 4'd8;
  localparam logic [3:0] NonceHdrBytes = 4'd12;

  localparam logic [31:0] MaxLogLengthReset = 32'd4096;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        byte_valid;
    logic [7:0]  text_byte;
    logic [63:0] nonce;
    logic [31:0] log_length;
  } out_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [31:0] wdata;
  } cfg_t;

endpackage

@@ src/ipcfd_stream_if.sv @@
// Valid/ready channel interface used by every port of the IPC frame deframer.
// Depends on nothing; the payload type is set where the channel is declared.
interface ipcfd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

@@ src/ipc_frame_deframer_top.sv @@
// IPC frame deframer: splits a received byte stream into tagged frames.
// Depends on ipcfd_pkg and ipcfd_stream_if.
//
// Usage:
//   rx_i  carries one received byte per transaction (payload rx_byte).
//   res_o carries one result per accepted byte: status, byte_valid,
//         text_byte, nonce and log_length.
//   cfg_i writes the four frame tags and the log length limit; its ready is
//         always high. Write only while no byte is in flight.
// Each result is registered and presented in the cycle after its byte is taken.
// Throughput: one byte per cycle while res_o.ready does not stall the result
//   register; the header parse, tag compare and length check of a byte all
//   complete in the single stage before the result register.
// Stall: the result register holds its transaction while res_o.ready is low;
//   rx_i.ready follows "result register empty or being taken", so a new byte
//   enters in the same cycle the previous result leaves.
// Reset: clears the frame state, the dead-link flag and the result register,
//   loads all tags with zero and the log length limit with 4096.
// After an unknown tag, an oversized log length or a zero activation nonce the
//   block reports invalid once and then answers disconnected to every byte
//   until reset.
module ipc_frame_deframer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  ipcfd_stream_if.sink    rx_i,
  ipcfd_stream_if.source  res_o,
  ipcfd_stream_if.sink    cfg_i
);
  import ipcfd_pkg::*;

  // Configuration registers
  logic [31:0] tag_log_q, tag_shut_q, tag_ready_q, tag_act_q, max_len_q;

  // Frame state
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] tag_q, tag_d;
  kind_e       kind_q, kind_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [63:0] nonce_q, nonce_d;
  logic        payload_q, payload_d;
  logic        dead_q, dead_d;

  // Result register
  out_t res_q, res_d;
  logic res_valid_q;

  logic        in_fire;
  logic [7:0]  rx_byte;
  logic [3:0]  hdr_inc;
  logic [31:0] tag_shift, len_shift, left_dec;
  logic [63:0] nonce_shift;

  assign rx_byte     = rx_i.payload.rx_byte;
  assign rx_i.ready  = !res_valid_q || res_o.ready;
  assign in_fire     = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  assign hdr_inc     = hdr_cnt_q + 4'd1;
  assign tag_shift   = {tag_q[23:0], rx_byte};
  assign len_shift   = {len_q[23:0], rx_byte};
  assign nonce_shift = {nonce_q[55:0], rx_byte};
  assign left_dec    = left_q - 32'd1;

  // Parse one byte: advance the header, pass text, or report the frame
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    tag_d     = tag_q;
    kind_d    = kind_q;
    len_d     = len_q;
    left_d    = left_q;
    nonce_d   = nonce_q;
    payload_d = payload_q;
    dead_d    = dead_q;
    res_d     = '0;
    res_d.status = StNeed;

    if (dead_q) begin
      res_d.status = StDead;
    end else if (payload_q) begin
      res_d.byte_valid = 1'b1;
      res_d.text_byte  = rx_byte;
      res_d.log_length = len_q;
      left_d           = left_dec;
      if (left_dec == 32'd0) begin
        hdr_cnt_d    = '0;
        payload_d    = 1'b0;
        res_d.status = StLogEnd;
      end else begin
        res_d.status = StLogByte;
      end
    end else begin
      hdr_cnt_d = hdr_inc;
      if (hdr_inc <= TagBytes) begin
        tag_d = tag_shift;
        if (hdr_inc == TagBytes) begin
          priority if (tag_shift == tag_log_q) begin
            kind_d = KindLog;
          end else if (tag_shift == tag_shut_q) begin
            kind_d       = KindShutdown;
            hdr_cnt_d    = '0;
            res_d.status = StShutdown;
          end else if (tag_shift == tag_ready_q) begin
            kind_d = KindReady;
          end else if (tag_shift == tag_act_q) begin
            kind_d = KindActivate;
          end else begin
            dead_d       = 1'b1;
            hdr_cnt_d    = '0;
            res_d.status = StInvalid;
          end
        end
      end else if (kind_q == KindLog) begin
        len_d = len_shift;
        if (hdr_inc >= LogHdrBytes) begin
          res_d.log_length = len_shift;
          priority if (len_shift > max_len_q) begin
            dead_d       = 1'b1;
            hdr_cnt_d    = '0;
            res_d.status = StInvalid;
          end else if (len_shift == 32'd0) begin
            hdr_cnt_d    = '0;
            res_d.status = StLogEnd;
          end else begin
            left_d    = len_shift;
            payload_d = 1'b1;
          end
        end
      end else begin
        nonce_d = nonce_shift;
        if (hdr_inc >= NonceHdrBytes) begin
          hdr_cnt_d = '0;
          priority if (kind_q == KindReady) begin
            res_d.nonce  = nonce_shift;
            res_d.status = StReady;
          end else if (nonce_shift == 64'd0) begin
            dead_d       = 1'b1;
            res_d.status = StInvalid;
          end else begin
            res_d.nonce  = nonce_shift;
            res_d.status = StActivate;
          end
        end
      end
    end
  end

  // Take configuration writes; ignore indexes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_log_q   <= '0;
      tag_shut_q  <= '0;
      tag_ready_q <= '0;
      tag_act_q   <= '0;
      max_len_q   <= MaxLogLengthReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.reg_index)
        RegTagLogLine:    tag_log_q   <= cfg_i.payload.wdata;
        RegTagShutdown:   tag_shut_q  <= cfg_i.payload.wdata;
        RegTagReadyQuery: tag_ready_q <= cfg_i.payload.wdata;
        RegTagActivate:   tag_act_q   <= cfg_i.payload.wdata;
        RegMaxLogLength:  max_len_q   <= cfg_i.payload.wdata;
        default: ;
      endcase
    end
  end

  // Advance the frame state on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      tag_q     <= '0;
      kind_q    <= KindLog;
      len_q     <= '0;
      left_q    <= '0;
      nonce_q   <= '0;
      payload_q <= 1'b0;
      dead_q    <= 1'b0;
    end else if (in_fire) begin
      hdr_cnt_q <= hdr_cnt_d;
      tag_q     <= tag_d;
      kind_q    <= kind_d;
      len_q     <= len_d;
      left_q    <= left_d;
      nonce_q   <= nonce_d;
      payload_q <= payload_d;
      dead_q    <= dead_d;
    end
  end

  // Hold the result until it is taken; load a new one on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

endmodule

@@ src/ipcfd_checker.sv @@
// Port-level checker of the IPC frame deframer and its bind to the top level.
// Depends on ipcfd_pkg and ipc_frame_deframer_top_assert.svh.
`include "ipc_frame_deframer_top_assert.svh"

module ipcfd_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ipcfd_pkg::out_t    out_payload_i
);
  import ipcfd_pkg::*;

  logic out_fire;
  logic dead_seen_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Remember that a fatal fault has been reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_seen_q <= 1'b0;
    end else if (out_fire && (out_payload_i.status == StInvalid ||
                              out_payload_i.status == StDead)) begin
      dead_seen_q <= 1'b1;
    end
  end

  `IPCFD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i,
                     "result dropped while stalled")
  `IPCFD_ASSERT_NEXT(a_in_to_out, in_valid_i && in_ready_i, out_valid_i,
                     "accepted byte gave no result")
  `IPCFD_ASSERT_NOW(a_in_ready_free, !out_valid_i, in_ready_i,
                    "input not ready with empty result register")
  `IPCFD_ASSERT_NOW(a_dead_sticky, out_valid_i && dead_seen_q,
                    out_payload_i.status == StDead, "link revived before reset")
  `IPCFD_ASSERT_NOW(a_text_status, out_valid_i && out_payload_i.byte_valid,
                    out_payload_i.status == StLogByte || out_payload_i.status == StLogEnd,
                    "text byte outside a log frame")

endmodule

bind ipc_frame_deframer_top ipcfd_port_checker u_ipcfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (rx_i.valid),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);
